// File: rtl/core/brle_pkg.sv
// shared types, constants and helpers of the block zero-run encoder
`default_nettype none

package brle_pkg;

  // field widths
  localparam int COEF_WIDTH    = 16;
  localparam int COUNT_WIDTH   = 16;
  localparam int POS_WIDTH     = 11;
  localparam int THR_WIDTH     = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int MAX_SYMS      = 4;
  localparam int SYM_CNT_W     = 3;

  // longest block length; the position counter stays below it
  localparam logic [POS_WIDTH-1:0] MAX_BLOCK_LEN = POS_WIDTH'(1024);

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HI_PRI_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 2'd2;

  // register reset values
  localparam logic [POS_WIDTH-1:0] RST_BLOCK_LENGTH = POS_WIDTH'(64);
  localparam logic [POS_WIDTH-1:0] RST_HI_PRI_COUNT = POS_WIDTH'(1);
  localparam logic [THR_WIDTH-1:0] RST_THRESHOLD    = THR_WIDTH'(1);

  // channel codes
  localparam logic CH_HIGH = 1'b0;
  localparam logic CH_LOW  = 1'b1;

  // symbol kinds
  typedef enum logic [2:0] {
    KIND_COEF   = 3'd0,
    KIND_SOB    = 3'd1,
    KIND_BLKNUM = 3'd2,
    KIND_SOR    = 3'd3,
    KIND_RUNLEN = 3'd4
  } kind_t;

  // input word
  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] coefficient;
    logic                         frame_start;
  } in_word_t;

  // output word
  typedef struct packed {
    logic                         channel;
    logic [2:0]                   kind;
    logic signed [COEF_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0]       count;
    logic                         last;
  } out_word_t;

  // one symbol before the last flag is known
  typedef struct packed {
    logic                         channel;
    kind_t                        kind;
    logic signed [COEF_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0]       count;
  } sym_t;

  // all symbols caused by one coefficient
  typedef struct packed {
    logic [SYM_CNT_W-1:0]   cnt;
    sym_t [MAX_SYMS-1:0]    syms;
  } sym_group_t;

  // configuration registers
  typedef struct packed {
    logic [POS_WIDTH-1:0] block_length;
    logic [POS_WIDTH-1:0] hi_pri_count;
    logic [THR_WIDTH-1:0] threshold;
  } cfg_t;

  function automatic sym_t mk_sym(input logic ch, input kind_t kd,
                                  input logic signed [COEF_WIDTH-1:0] val,
                                  input logic [COUNT_WIDTH-1:0] cnt);
    sym_t s;
    s.channel = ch;
    s.kind    = kd;
    s.value   = val;
    s.count   = cnt;
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/brle_stream_if.sv
// valid/ready stream channel carrying one word per handshake
`default_nettype none

interface brle_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/block_zero_run_encoder.sv
// Block zero-run encoder: takes one coefficient per word on coefs and emits
// symbol words on symbols. A coefficient is first held in the input register,
// then its symbols (zero to four) are decided in a single pass and loaded into
// the result register together; the result register hands them out one word
// per cycle while symbols is ready, the final one flagged last. With zero or
// one symbol per coefficient the sustained rate is one coefficient per cycle
// while the output is ready; a coefficient with more holds the result register
// until its last word leaves, when the next moves up. Configuration writes take
// effect at once, including on a word still waiting in the input register, so
// write the registers only while no coefficient is in flight.
`default_nettype none

module block_zero_run_encoder
  import brle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  brle_stream_if.sink            coefs,
  brle_stream_if.source          symbols
);

  cfg_t       cfg;
  in_word_t   ireg_data;
  logic       ireg_valid;
  logic       take;
  logic       free;
  sym_group_t grp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_length <= RST_BLOCK_LENGTH;
      cfg.hi_pri_count <= RST_HI_PRI_COUNT;
      cfg.threshold    <= RST_THRESHOLD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BLOCK_LENGTH: cfg.block_length <= cfg_data[POS_WIDTH-1:0];
        REG_HI_PRI_COUNT: cfg.hi_pri_count <= cfg_data[POS_WIDTH-1:0];
        REG_THRESHOLD:    cfg.threshold    <= cfg_data[THR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign take        = ireg_valid && free;
  assign coefs.ready = !ireg_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (coefs.valid && coefs.ready) begin
      ireg_valid <= 1'b1;
    end else if (take) begin
      ireg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (coefs.valid && coefs.ready) begin
      ireg_data <= coefs.data;
    end
  end

  // symbol decision
  brle_encode u_encode (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (ireg_data),
    .advance (take),
    .grp     (grp)
  );

  // result register
  brle_outbuf u_outbuf (
    .clk     (clk),
    .rst     (rst),
    .grp     (grp),
    .load    (take),
    .free    (free),
    .symbols (symbols)
  );

  // a waiting word stays put until the result register frees up
  a_ireg_hold: assert property (@(posedge clk) disable iff (rst)
    ireg_valid && !take |=> ireg_valid && $stable(ireg_data))
    else $error("input register lost or changed a waiting word");

  // the last word of a coefficient empties the result register unless refilled
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    symbols.valid && symbols.ready && symbols.data.last && !take |=> !symbols.valid)
    else $error("symbols left over after last");

  // high-priority channel carries coefficients only
  a_high_coef: assert property (@(posedge clk) disable iff (rst)
    symbols.valid && symbols.data.channel == CH_HIGH |->
      symbols.data.kind == KIND_COEF)
    else $error("non-coefficient symbol on high-priority channel");

  // a run length is never zero
  a_runlen_nonzero: assert property (@(posedge clk) disable iff (rst)
    symbols.valid && symbols.data.kind == KIND_RUNLEN |-> symbols.data.count != '0)
    else $error("zero run length emitted");

endmodule

`default_nettype wire

// File: rtl/core/brle_encode.sv
// per-coefficient symbol decision and block/run state
`default_nettype none

module brle_encode
  import brle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  in_word_t   item,
  input  logic       advance,
  output sym_group_t grp
);

  logic [POS_WIDTH-1:0]   pos;
  logic [POS_WIDTH-1:0]   run;
  logic [COUNT_WIDTH-1:0] bn;
  logic [POS_WIDTH-1:0]   pos_next;
  logic [POS_WIDTH-1:0]   run_next;
  logic [COUNT_WIDTH-1:0] bn_next;

  // symbol selection for the word in the input register
  always_comb begin
    logic [COEF_WIDTH:0]    ext;
    logic [COEF_WIDTH:0]    mag;
    logic                   sig;
    logic [POS_WIDTH-1:0]   len;
    logic [POS_WIDTH-1:0]   hi;
    logic [POS_WIDTH-1:0]   pos_e;
    logic [POS_WIDTH-1:0]   run_e;
    logic [POS_WIDTH-1:0]   run1;
    logic [COUNT_WIDTH-1:0] bn_e;
    logic [POS_WIDTH:0]     pos_inc;
    logic                   blk_end;
    logic [SYM_CNT_W-1:0]   n;
    sym_t [MAX_SYMS-1:0]    syms;

    // magnitude test
    ext = {item.coefficient[COEF_WIDTH-1], item.coefficient};
    mag = item.coefficient[COEF_WIDTH-1] ? (~ext + 1'b1) : ext;
    sig = mag >= {1'b0, cfg.threshold};

    // effective block length and high-priority count
    if (cfg.block_length == '0) begin
      len = POS_WIDTH'(1);
    end else if (cfg.block_length > MAX_BLOCK_LEN) begin
      len = MAX_BLOCK_LEN;
    end else begin
      len = cfg.block_length;
    end
    hi = (cfg.hi_pri_count < len) ? cfg.hi_pri_count : len;

    // frame start restarts everything
    pos_e = item.frame_start ? '0 : pos;
    run_e = item.frame_start ? '0 : run;
    bn_e  = item.frame_start ? '0 : bn;

    pos_inc = {1'b0, pos_e} + 1'b1;
    blk_end = pos_inc >= {1'b0, len};

    n    = '0;
    syms = '0;
    run1 = run_e;

    // header ahead of the block when nothing is high priority
    if (hi == '0 && pos_e == '0) begin
      syms[n[1:0]] = mk_sym(CH_LOW, KIND_SOB, '0, '0);
      n = n + 1'b1;
      syms[n[1:0]] = mk_sym(CH_LOW, KIND_BLKNUM, '0, bn_e);
      n = n + 1'b1;
    end

    if (pos_e < hi) begin
      // high-priority coefficient, header after the last one
      syms[n[1:0]] = mk_sym(CH_HIGH, KIND_COEF, item.coefficient, '0);
      n = n + 1'b1;
      if (pos_inc == {1'b0, hi}) begin
        syms[n[1:0]] = mk_sym(CH_LOW, KIND_SOB, '0, '0);
        n = n + 1'b1;
        syms[n[1:0]] = mk_sym(CH_LOW, KIND_BLKNUM, '0, bn_e);
        n = n + 1'b1;
      end
    end else if (run_e != '0) begin
      // inside a run: close it or extend it
      if (sig) begin
        syms[n[1:0]] = mk_sym(CH_LOW, KIND_RUNLEN, '0, COUNT_WIDTH'(run_e));
        n = n + 1'b1;
        syms[n[1:0]] = mk_sym(CH_LOW, KIND_COEF, item.coefficient, '0);
        n = n + 1'b1;
        run1 = '0;
      end else begin
        run1 = run_e + 1'b1;
      end
    end else begin
      // outside a run: pass the value or open a run
      if (sig) begin
        syms[n[1:0]] = mk_sym(CH_LOW, KIND_COEF, item.coefficient, '0);
        n = n + 1'b1;
      end else begin
        syms[n[1:0]] = mk_sym(CH_LOW, KIND_SOR, '0, '0);
        n = n + 1'b1;
        run1 = POS_WIDTH'(1);
      end
    end

    // block end flushes a pending run
    if (blk_end && run1 != '0) begin
      syms[n[1:0]] = mk_sym(CH_LOW, KIND_RUNLEN, '0, COUNT_WIDTH'(run1));
      n = n + 1'b1;
      run1 = '0;
    end

    grp.cnt  = n;
    grp.syms = syms;

    run_next = run1;
    pos_next = blk_end ? '0 : pos_inc[POS_WIDTH-1:0];
    bn_next  = blk_end ? bn_e + 1'b1 : bn_e;
  end

  // block and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      run <= '0;
      bn  <= '0;
    end else if (advance) begin
      pos <= pos_next;
      run <= run_next;
      bn  <= bn_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/brle_outbuf.sv
// result register: holds one coefficient's symbols and hands them out in order
`default_nettype none

module brle_outbuf
  import brle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sym_group_t grp,
  input  logic       load,
  output logic       free,
  brle_stream_if.source symbols
);

  sym_t [MAX_SYMS-1:0]  ent;
  logic [SYM_CNT_W-1:0] cnt;
  logic                 fire;

  assign symbols.valid        = cnt != '0;
  assign fire                 = symbols.valid && symbols.ready;
  assign free                 = (cnt == '0) || (cnt == SYM_CNT_W'(1) && fire);

  // head word, last when it is the only one left
  assign symbols.data.channel = ent[0].channel;
  assign symbols.data.kind    = ent[0].kind;
  assign symbols.data.value   = ent[0].value;
  assign symbols.data.count   = ent[0].count;
  assign symbols.data.last    = cnt == SYM_CNT_W'(1);

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= grp.cnt;
    end else if (fire) begin
      cnt <= cnt - 1'b1;
    end
  end

  // symbol slots, shifted toward the head
  always_ff @(posedge clk) begin
    if (load) begin
      ent <= grp.syms;
    end else if (fire) begin
      for (int i = 0; i < MAX_SYMS - 1; i++) begin
        ent[i] <= ent[i+1];
      end
      ent[MAX_SYMS-1] <= '0;
    end
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for the block zero-run encoder
module tb
  import brle_pkg::*;
();

  // unused register index, writes to it must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd3;

  // how a coefficient value is drawn
  localparam int COEF_BELOW = 0;
  localparam int COEF_SIG   = 1;
  localparam int COEF_RAW   = 2;
  localparam int COEF_EDGE  = 3;

  // how a block is filled
  localparam int DENS_SPARSE = 0;
  localparam int DENS_MIXED  = 1;
  localparam int DENS_RAW    = 2;
  localparam int DENS_QUIET  = 3;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 150;
  localparam int STALL_LIMIT   = 2000;

  typedef struct {
    in_word_t word;
    bit       wait_drain;
  } pending_coef_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  brle_stream_if #(.word_t(in_word_t))  coefs_if ();
  brle_stream_if #(.word_t(out_word_t)) syms_if ();

  block_zero_run_encoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs_if),
    .symbols   (syms_if)
  );

  // register copies and encoder state of the predictor
  logic [POS_WIDTH-1:0] cfg_len_reg = RST_BLOCK_LENGTH;
  logic [POS_WIDTH-1:0] cfg_hi_reg  = RST_HI_PRI_COUNT;
  logic [THR_WIDTH-1:0] cfg_thr_reg = RST_THRESHOLD;
  int                   blk_pos   = 0;
  int                   open_run  = 0;
  logic [15:0]          blk_count = '0;

  pending_coef_t pending_coefs[$];
  pending_coef_t next_item;
  out_word_t     expected_syms[$];

  bit coef_hs;
  bit src_idle_on;
  bit snk_idle_on;
  bit hold_req;
  bit hold_done;
  int src_gap;
  int snk_gap;
  int hold_left;
  int err_count;
  int items_sent;
  int syms_checked;
  int settings_run;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int clamp_len(input logic [POS_WIDTH-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_BLOCK_LEN) return int'(MAX_BLOCK_LEN);
    return int'(v);
  endfunction

  function automatic out_word_t make_word(input logic ch, input kind_t kd,
                                          input logic [15:0] val,
                                          input logic [15:0] cnt);
    out_word_t w;
    w.channel = ch;
    w.kind    = kd;
    w.value   = val;
    w.count   = cnt;
    w.last    = 1'b0;
    return w;
  endfunction

  // symbols caused by one accepted coefficient word
  function automatic void encode_coef(input in_word_t w);
    out_word_t batch[$];
    int        coef;
    int        mag;
    int        len;
    int        hi;
    bit        sig;
    coef = $signed(w.coefficient);
    mag  = (coef < 0) ? -coef : coef;
    sig  = mag >= int'(cfg_thr_reg);
    if (w.frame_start) begin
      blk_pos   = 0;
      open_run  = 0;
      blk_count = '0;
    end
    len = clamp_len(cfg_len_reg);
    hi  = (int'(cfg_hi_reg) < len) ? int'(cfg_hi_reg) : len;
    // header ahead of the block when nothing is high priority
    if (hi == 0 && blk_pos == 0) begin
      batch.push_back(make_word(CH_LOW, KIND_SOB, '0, '0));
      batch.push_back(make_word(CH_LOW, KIND_BLKNUM, '0, blk_count));
    end
    if (blk_pos < hi) begin
      batch.push_back(make_word(CH_HIGH, KIND_COEF, w.coefficient, '0));
      if (blk_pos + 1 == hi) begin
        batch.push_back(make_word(CH_LOW, KIND_SOB, '0, '0));
        batch.push_back(make_word(CH_LOW, KIND_BLKNUM, '0, blk_count));
      end
    end else if (open_run != 0) begin
      if (sig) begin
        batch.push_back(make_word(CH_LOW, KIND_RUNLEN, '0, 16'(open_run)));
        open_run = 0;
        batch.push_back(make_word(CH_LOW, KIND_COEF, w.coefficient, '0));
      end else begin
        open_run = (open_run + 1) & 'h7FF;
      end
    end else if (sig) begin
      batch.push_back(make_word(CH_LOW, KIND_COEF, w.coefficient, '0));
    end else begin
      batch.push_back(make_word(CH_LOW, KIND_SOR, '0, '0));
      open_run = 1;
    end
    // block end flushes a pending run
    if (blk_pos + 1 >= len) begin
      if (open_run != 0) begin
        batch.push_back(make_word(CH_LOW, KIND_RUNLEN, '0, 16'(open_run)));
        open_run = 0;
      end
      blk_pos   = 0;
      blk_count = blk_count + 16'd1;
    end else begin
      blk_pos = (blk_pos + 1) & 'h7FF;
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_syms.push_back(batch[i]);
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40) $display("mismatch at word %0d: %s", syms_checked, what);
  endtask

  // compare one symbol word with the oldest expectation
  task automatic check_symbol(input out_word_t got);
    out_word_t want;
    if (expected_syms.size() == 0) begin
      report_mismatch($sformatf("unexpected word ch %0d kind %0d value %0d count %0d",
                                got.channel, got.kind, $signed(got.value), got.count));
    end else begin
      want = expected_syms.pop_front();
      if (got.channel !== want.channel)
        report_mismatch($sformatf("channel %0d, want %0d", got.channel, want.channel));
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.value !== want.value)
        report_mismatch($sformatf("value %0d, want %0d", $signed(got.value),
                                  $signed(want.value)));
      if (got.count !== want.count)
        report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
    end
    syms_checked++;
  endtask

  // handshake monitor: predict on input, check on output
  always @(posedge clk) begin
    if (rst) begin
      coef_hs <= 1'b0;
    end else begin
      coef_hs <= coefs_if.valid && coefs_if.ready;
      if (coefs_if.valid && coefs_if.ready) encode_coef(coefs_if.data);
      if (syms_if.valid && syms_if.ready) check_symbol(syms_if.data);
    end
  end

  // coefficient driver
  always @(negedge clk) begin
    if (rst) begin
      coefs_if.valid <= 1'b0;
      coefs_if.data  <= '0;
      src_gap = 0;
    end else if (coef_hs || !coefs_if.valid) begin
      if (src_gap == 0 && src_idle_on && $urandom_range(0, 7) == 0)
        src_gap = $urandom_range(1, 15);
      if (src_gap > 0) begin
        src_gap--;
        coefs_if.valid <= 1'b0;
      end else if (pending_coefs.size() > 0 &&
                   !(pending_coefs[0].wait_drain && expected_syms.size() != 0)) begin
        next_item = pending_coefs.pop_front();
        coefs_if.data  <= next_item.word;
        coefs_if.valid <= 1'b1;
        items_sent++;
      end else begin
        coefs_if.valid <= 1'b0;
      end
    end
  end

  // symbol receiver, with random stalls and one long hold
  always @(negedge clk) begin
    if (rst) begin
      syms_if.ready <= 1'b0;
      snk_gap   = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        syms_if.ready <= 1'b0;
      end else begin
        if (snk_gap == 0 && snk_idle_on && $urandom_range(0, 7) == 0)
          snk_gap = $urandom_range(1, 15);
        if (snk_gap > 0) begin
          snk_gap--;
          syms_if.ready <= 1'b0;
        end else begin
          syms_if.ready <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    @(negedge rst);
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((coefs_if.valid && coefs_if.ready) || (syms_if.valid && syms_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("timeout: no word moved for %0d cycles, %0d symbols outstanding",
             STALL_LIMIT, expected_syms.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [15:0] pick_coef(input int mode, input int thr);
    int m;
    if (mode == COEF_RAW) return 16'($urandom);
    if (mode == COEF_EDGE) begin
      case ($urandom_range(0, 4))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        3: return 16'h0001;
        default: return 16'hFFFF;
      endcase
    end
    if (mode == COEF_BELOW && thr > 0) begin
      m = $urandom_range(0, (thr > 32767) ? 32767 : thr - 1);
      return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
    end
    // significant: magnitude from the threshold up to 32768
    m = $urandom_range(thr, 32768);
    if (m == 32768) return 16'h8000;
    return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
  endfunction

  function automatic void add_coef(input logic [15:0] c, input bit fs, input bit drain);
    pending_coef_t p;
    p.word.coefficient = c;
    p.word.frame_start = fs;
    p.wait_drain       = drain;
    pending_coefs.push_back(p);
  endfunction

  // one block of coefficients, optionally with stray frame restarts inside
  function automatic int queue_block(input int len, input int thr, input int density,
                                     input bit fs, input bit drain, input bit noisy);
    int mode;
    for (int i = 0; i < len; i++) begin
      if (density == DENS_QUIET) mode = COEF_BELOW;
      else if ($urandom_range(0, 15) == 0) mode = COEF_EDGE;
      else if (density == DENS_RAW) mode = COEF_RAW;
      else if ($urandom_range(0, 9) < ((density == DENS_SPARSE) ? 8 : 4)) mode = COEF_BELOW;
      else mode = COEF_SIG;
      add_coef(pick_coef(mode, thr),
               (i == 0) ? fs : (noisy && $urandom_range(0, 39) == 0),
               (i == 0) && drain);
    end
    return len;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_BLOCK_LENGTH: cfg_len_reg = data[POS_WIDTH-1:0];
      REG_HI_PRI_COUNT: cfg_hi_reg  = data[POS_WIDTH-1:0];
      REG_THRESHOLD:    cfg_thr_reg = data;
      default: ;
    endcase
  endtask

  // wait until every word is through and the pipeline has emptied
  task automatic wait_idle();
    while (pending_coefs.size() != 0 || coefs_if.valid || expected_syms.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int len, input int hi, input int thr);
    wait_idle();
    write_reg(REG_BLOCK_LENGTH, 16'(len));
    write_reg(REG_HI_PRI_COUNT, 16'(hi));
    write_reg(REG_THRESHOLD, 16'(thr));
    settings_run++;
  endtask

  // stimulus sequence
  initial begin
    int rand_items;
    int len_w;
    int hi_w;
    int thr_w;
    int len_eff;
    int nblk;
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    src_idle_on    = 1'b1;
    snk_idle_on    = 1'b1;
    hold_req       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: runs broken and flushed, extremes, frame restart mid-block
    set_config(4, 1, 100);
    add_coef(16'h7FFF, 1'b1, 1'b0);
    add_coef(16'd0, 1'b0, 1'b0);
    add_coef(-16'sd99, 1'b0, 1'b0);
    add_coef(16'd99, 1'b0, 1'b0);
    add_coef(16'h8000, 1'b0, 1'b0);
    add_coef(16'd100, 1'b0, 1'b0);
    add_coef(-16'sd100, 1'b0, 1'b0);
    add_coef(16'd5, 1'b0, 1'b0);
    add_coef(16'd1, 1'b0, 1'b0);
    add_coef(16'd50, 1'b0, 1'b0);
    add_coef(16'h8000, 1'b0, 1'b0);
    add_coef(16'd0, 1'b0, 1'b0);
    add_coef(16'd7, 1'b0, 1'b0);
    add_coef(16'd3, 1'b0, 1'b0);
    add_coef(16'd9, 1'b1, 1'b0);
    add_coef(16'd0, 1'b0, 1'b0);
    add_coef(16'd200, 1'b0, 1'b0);
    add_coef(16'd0, 1'b0, 1'b0);

    // zero length acts as one, header first, every value significant
    set_config(0, 0, 0);
    add_coef(16'd0, 1'b0, 1'b0);
    add_coef(16'hFFFF, 1'b0, 1'b0);

    // high-priority count beyond the block, top threshold
    set_config(3, 5, 32768);
    add_coef(16'h8000, 1'b0, 1'b0);
    add_coef(16'h7FFF, 1'b0, 1'b0);
    add_coef(16'd0, 1'b0, 1'b0);

    // shrink the block while a run is open mid-block
    set_config(8, 0, 32768);
    add_coef(16'h8000, 1'b0, 1'b0);
    add_coef(16'h7FFF, 1'b0, 1'b0);
    add_coef(16'd0, 1'b0, 1'b0);
    set_config(2, 0, 32768);
    write_reg(REG_NONE, 16'h0005);
    add_coef(16'd1, 1'b0, 1'b0);

    // largest block, all high priority, cut short by a smaller length
    set_config(1024, 1024, 32768);
    void'(queue_block(20, 32768, DENS_RAW, 1'b1, 1'b0, 1'b0));
    set_config(4, 1024, 32768);
    add_coef(16'd3, 1'b0, 1'b0);

    // oversized length saturates, a long run closed by a smaller length
    set_config(2047, 0, 32768);
    write_reg(REG_BLOCK_LENGTH, 16'hFFFF);
    void'(queue_block(20, 32768, DENS_QUIET, 1'b0, 1'b0, 1'b0));
    set_config(4, 0, 32768);
    add_coef(16'd0, 1'b0, 1'b0);

    // back-pressure: receiver holds off while the sender keeps offering
    rand_items = 0;
    set_config(8, 2, 40);
    src_idle_on = 1'b0;
    snk_idle_on = $urandom_range(0, 1);
    for (int b = 0; b < 6; b++)
      rand_items += queue_block(8, 40, DENS_MIXED, b == 0, b == 4, 1'b1);
    hold_req = 1'b1;

    // random settings and blocks
    while (rand_items < 150) begin
      case ($urandom_range(0, 9))
        0:       len_w = 0;
        1, 2:    len_w = $urandom_range(13, 40);
        default: len_w = $urandom_range(1, 12);
      endcase
      len_eff = clamp_len(POS_WIDTH'(len_w));
      hi_w = ($urandom_range(0, 7) == 0) ? 1024 : $urandom_range(0, len_eff + 2);
      case ($urandom_range(0, 4))
        0:       thr_w = 0;
        1:       thr_w = 1;
        2:       thr_w = $urandom_range(2, 300);
        3:       thr_w = $urandom_range(301, 32767);
        default: thr_w = 32768;
      endcase
      set_config(len_w, hi_w, thr_w);
      src_idle_on = $urandom_range(0, 3) != 0;
      snk_idle_on = $urandom_range(0, 3) != 0;
      nblk = (len_eff > 16) ? 1 : $urandom_range(1, 4);
      for (int b = 0; b < nblk; b++)
        rand_items += queue_block(len_eff, thr_w, $urandom_range(DENS_SPARSE, DENS_RAW),
                                  $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0,
                                  1'b1);
    end

    // closing stretch at full rate on both sides
    set_config(6, 1, 16);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    for (int b = 0; b < 5; b++)
      void'(queue_block(6, 16, $urandom_range(DENS_SPARSE, DENS_RAW), b == 0, 1'b0, 1'b1));
    wait_idle();

    $display("%0d coefficients over %0d register settings gave %0d symbol words",
             items_sent, settings_run, syms_checked);
    $display("block lengths 1 to 1024 with mid-block cuts, thresholds 0 to 32768, "
             , "frame restarts, long stalls");
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: files.f
rtl/core/brle_pkg.sv
rtl/core/brle_stream_if.sv
rtl/core/brle_encode.sv
rtl/core/brle_outbuf.sv
rtl/core/block_zero_run_encoder.sv
tb/tb.sv
